// ===== src/bitmap_page_range_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// bitmap page range allocator assertion macros
// shared assertion forms for the allocator's own checks
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_RANGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_RANGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPRA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bpra: same-cycle check failed");

// next-cycle implication
`define BPRA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bpra: next-cycle check failed");

`endif

// ===== src/bpra_pkg.sv =====
// ----------------------------------------------------------------------------
// bpra_pkg
// shared widths, codes and types of the bitmap page range allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bpra_pkg;

  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 13;
  localparam int START_W    = 12;
  localparam int STATUS_W   = 2;
  localparam int PAGE_SHIFT = 12;
  localparam int WORD_W     = 32;
  localparam int BIT_W      = 5;
  localparam int IDX_W      = ADDR_W - PAGE_SHIFT;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NO_SPACE     = 2'd1,
    STATUS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic             found;
    logic             carry;
    logic             word_free;
    logic [BIT_W-1:0] fit_off;
    logic [BIT_W:0]   lead_free;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/bpra_if.sv =====
// ----------------------------------------------------------------------------
// bpra channel interfaces
// request, result and register write channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bpra_in_if import bpra_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [COUNT_W-1:0] page_count;
  logic [ADDR_W-1:0]  free_address;

  modport source (output valid, output kind, output page_count, output free_address,
                  input ready);
  modport sink   (input valid, input kind, input page_count, input free_address,
                  output ready);
endinterface

interface bpra_out_if import bpra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   run_address;
  logic [START_W-1:0]  run_start_page;

  modport source (output valid, output status, output run_address, output run_start_page,
                  input ready);
  modport sink   (input valid, input status, input run_address, input run_start_page,
                  output ready);
endinterface

interface bpra_cfg_if import bpra_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] wdata;

  modport source (output valid, output wdata, input ready);
  modport sink   (input valid, input wdata, output ready);
endinterface

`default_nettype wire

// ===== src/bpra_ram.sv =====
// ----------------------------------------------------------------------------
// bpra_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 128,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/bpra_scan.sv =====
// ----------------------------------------------------------------------------
// bpra_scan
// first-fit evaluation of one occupancy word against the run carried in
// ----------------------------------------------------------------------------
`default_nettype none

module bpra_scan import bpra_pkg::*; #(
  parameter int CW = 13
) (
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [CW-1:0]     run_in,
  input  wire logic [CW-1:0]     count,
  output scan_res_t              res
);

  logic [BIT_W:0]    tz;
  logic [BIT_W:0]    lz;
  logic [WORD_W-1:0] nmask;
  logic [WORD_W-1:0] fit;
  logic [BIT_W-1:0]  off;
  logic              carry;

  always_comb begin
    tz    = (BIT_W+1)'(WORD_W);
    lz    = (BIT_W+1)'(WORD_W);
    fit   = '0;
    off   = '0;
    nmask = (count >= CW'(WORD_W)) ? '1 : ~({WORD_W{1'b1}} << count[BIT_W-1:0]);
    // lowest used bit gives the free run at the bottom
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (word[i]) begin
        tz = (BIT_W+1)'(i);
      end
    end
    // highest used bit gives the free run at the top
    for (int i = 0; i < WORD_W; i++) begin
      if (word[i]) begin
        lz = (BIT_W+1)'(WORD_W - 1 - i);
      end
    end
    for (int s = 0; s < WORD_W; s++) begin
      fit[s] = (((word >> s) & nmask) == '0) && (count <= CW'(WORD_W - s));
    end
    for (int s = WORD_W - 1; s >= 0; s--) begin
      if (fit[s]) begin
        off = BIT_W'(s);
      end
    end
    carry = (run_in != '0) && ((run_in + CW'(tz)) >= count);
  end

  assign res.found     = carry || (|fit);
  assign res.carry     = carry;
  assign res.word_free = (word == '0);
  assign res.fit_off   = off;
  assign res.lead_free = lz;

endmodule

`default_nettype wire

// ===== src/bitmap_page_range_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_range_allocator
// first-fit page run allocator over a one-bit-per-page occupancy map.
// in_ch carries one request word: kind (allocate or free), page_count and
// free_address. out_ch returns one result word per request: status,
// run_address and run_start_page. cfg_ch writes region_base, the address of
// page 0; it is always ready; the user must write it only while the block
// is idle, which the block does not enforce. the map lives in a ram of
// ceil(NUM_PAGES/32) words, one read and one write per cycle, so the ram
// port sets the pace. allocate: setup latches and checks the request, then
// map words are read and scanned in order until a run fits, then its words
// are read and marked, then the result register is loaded.
// free: setup, then the run's words are read and cleared, then result.
// after reset a clearing pass writes every map word to zero, one word a
// cycle (128 words for 4096 pages); no request is taken until it ends.
// a finished result waits in the output register while out_ch stalls; the
// next request may be taken meanwhile but its result holds until that
// register drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_page_range_allocator_macros.svh"

module bitmap_page_range_allocator import bpra_pkg::*; #(
  parameter int NUM_PAGES = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bpra_in_if.sink     in_ch,
  bpra_out_if.source  out_ch,
  bpra_cfg_if.sink    cfg_ch
);

  localparam int MAP_WORDS = (NUM_PAGES + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = AW + BIT_W;
  localparam int CW        = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;
  localparam int TAIL      = NUM_PAGES % WORD_W;
  localparam logic [WORD_W-1:0] TAIL_USED =
    (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));
  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

  state_t             state_r, state_nxt;
  kind_t              kind_r, kind_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  region_base_r;
  logic [PW-1:0]      start_r, start_nxt;
  logic [CW-1:0]      run_r, run_nxt;
  logic [PW-1:0]      begin_r, begin_nxt;
  status_t            status_r, status_nxt;
  logic [AW-1:0]      issue_r, issue_nxt;
  logic               issue_en_r, issue_en_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic [AW-1:0]      pword_r, pword_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [START_W-1:0] out_start_r, out_start_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [WORD_W-1:0]  ram_rdata;

  logic [WORD_W-1:0]  scan_word;
  scan_res_t          scan_res;
  logic [CW-1:0]      count_ext;
  logic [PW-1:0]      found_start;
  logic [ADDR_W-1:0]  offset;
  logic [IDX_W-1:0]   idx;
  logic               free_oor;
  logic               alloc_bad;
  logic [PW-1:0]      last_page;
  logic [AW-1:0]      start_word;
  logic [AW-1:0]      end_word;
  logic [AW-1:0]      last_issue;
  logic [BIT_W-1:0]   lo_bit;
  logic [BIT_W-1:0]   hi_bit;
  logic [WORD_W-1:0]  run_mask;
  logic [ADDR_W-1:0]  start32;

  bpra_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign scan_word = ram_rdata | ((pword_r == LAST_WORD) ? TAIL_USED : '0);
  assign count_ext = CW'(count_r);

  bpra_scan #(
    .CW (CW)
  ) u_scan (
    .word   (scan_word),
    .run_in (run_r),
    .count  (count_ext),
    .res    (scan_res)
  );

  // request checks
  assign offset    = addr_r - region_base_r;
  assign idx       = offset[ADDR_W-1:PAGE_SHIFT];
  assign free_oor  = ({1'b0, idx} >= (IDX_W+1)'(NUM_PAGES)) ||
                     ((IDX_W+1)'(count_r) > ((IDX_W+1)'(NUM_PAGES) - {1'b0, idx}));
  assign alloc_bad = (count_r == '0) || (count_ext > CW'(NUM_PAGES));

  assign found_start = scan_res.carry ? begin_r : {pword_r, scan_res.fit_off};

  // run bounds and per-word mask
  assign last_page  = start_r + PW'(count_r) - PW'(1);
  assign start_word = start_r[PW-1:BIT_W];
  assign end_word   = last_page[PW-1:BIT_W];
  assign last_issue = (state_r == ST_SCAN) ? LAST_WORD : end_word;
  assign lo_bit     = (pword_r == start_word) ? start_r[BIT_W-1:0] : '0;
  assign hi_bit     = (pword_r == end_word) ? last_page[BIT_W-1:0] : '1;
  assign run_mask   = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
  assign start32    = ADDR_W'(start_r);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.run_address    = out_addr_r;
  assign out_ch.run_start_page = out_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      issue_en_r    <= 1'b0;
      rvalid_r      <= 1'b0;
      clr_r         <= '0;
      out_valid_r   <= 1'b0;
      region_base_r <= '0;
    end else begin
      state_r     <= state_nxt;
      issue_en_r  <= issue_en_nxt;
      rvalid_r    <= rvalid_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        region_base_r <= cfg_ch.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    count_r      <= count_nxt;
    addr_r       <= addr_nxt;
    start_r      <= start_nxt;
    run_r        <= run_nxt;
    begin_r      <= begin_nxt;
    status_r     <= status_nxt;
    issue_r      <= issue_nxt;
    pword_r      <= pword_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_start_r  <= out_start_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    start_nxt      = start_r;
    run_nxt        = run_r;
    begin_nxt      = begin_r;
    status_nxt     = status_r;
    issue_nxt      = issue_r;
    issue_en_nxt   = issue_en_r;
    rvalid_nxt     = 1'b0;
    pword_nxt      = pword_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_start_nxt  = out_start_r;
    ram_we         = 1'b0;
    ram_waddr      = pword_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = issue_r;

    // streaming reads for scan and mark
    if ((state_r == ST_SCAN || state_r == ST_MARK) && issue_en_r) begin
      ram_re     = 1'b1;
      rvalid_nxt = 1'b1;
      pword_nxt  = issue_r;
      if (issue_r == last_issue) begin
        issue_en_nxt = 1'b0;
      end else begin
        issue_nxt = issue_r + AW'(1);
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = kind_t'(in_ch.kind);
          count_nxt = in_ch.page_count;
          addr_nxt  = in_ch.free_address;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        issue_en_nxt = 1'b1;
        run_nxt      = '0;
        begin_nxt    = '0;
        if (kind_r == KIND_ALLOC) begin
          issue_nxt = '0;
          if (alloc_bad) begin
            status_nxt   = STATUS_NO_SPACE;
            start_nxt    = '0;
            issue_en_nxt = 1'b0;
            state_nxt    = ST_RESULT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else begin
          issue_nxt = idx[PW-1:BIT_W];
          if (free_oor) begin
            status_nxt   = STATUS_OUT_OF_RANGE;
            start_nxt    = '0;
            issue_en_nxt = 1'b0;
            state_nxt    = ST_RESULT;
          end else begin
            status_nxt = STATUS_OK;
            start_nxt  = idx[PW-1:0];
            if (count_r == '0) begin
              issue_en_nxt = 1'b0;
              state_nxt    = ST_RESULT;
            end else begin
              state_nxt = ST_MARK;
            end
          end
        end
      end
      ST_SCAN: begin
        if (rvalid_r) begin
          if (scan_res.found) begin
            start_nxt    = found_start;
            status_nxt   = STATUS_OK;
            issue_nxt    = found_start[PW-1:BIT_W];
            issue_en_nxt = 1'b1;
            rvalid_nxt   = 1'b0;
            state_nxt    = ST_MARK;
          end else begin
            if (scan_res.word_free) begin
              run_nxt   = run_r + CW'(WORD_W);
              begin_nxt = (run_r == '0) ? {pword_r, {BIT_W{1'b0}}} : begin_r;
            end else begin
              run_nxt   = CW'(scan_res.lead_free);
              begin_nxt = {pword_r, BIT_W'((BIT_W+1)'(WORD_W) - scan_res.lead_free)};
            end
            if (pword_r == LAST_WORD) begin
              status_nxt   = STATUS_NO_SPACE;
              start_nxt    = '0;
              issue_en_nxt = 1'b0;
              rvalid_nxt   = 1'b0;
              state_nxt    = ST_RESULT;
            end
          end
        end
      end
      ST_MARK: begin
        if (rvalid_r) begin
          ram_we    = 1'b1;
          ram_waddr = pword_r;
          ram_wdata = (kind_r == KIND_FREE) ? (ram_rdata & ~run_mask)
                                            : (ram_rdata | run_mask);
          if (pword_r == end_word) begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_addr_nxt   = (kind_r == KIND_ALLOC && status_r == STATUS_OK) ?
                           (region_base_r + (start32 << PAGE_SHIFT)) : '0;
          out_start_nxt  = (status_r == STATUS_OK) ? start32[START_W-1:0] : '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // read-modify-write never hits the word being written
  `BPRA_ASSERT_IMPL(a_rmw_no_collision, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr)

  // marking stays inside the run's words
  `BPRA_ASSERT_IMPL(a_mark_bounds, clk, rst_n, (state_r == ST_MARK) && ram_we, (ram_waddr >= start_word) && (ram_waddr <= end_word))

  // failed requests report neither address nor page
  `BPRA_ASSERT_IMPL(a_fail_zero, clk, rst_n, out_ch.valid && (out_ch.status != STATUS_OK), (out_ch.run_address == '0) && (out_ch.run_start_page == '0))

  // a loaded result is registered into the output and frees the controller
  `BPRA_ASSERT_NEXT(a_result_load, clk, rst_n, (state_r == ST_RESULT) && (!out_valid_r || out_ch.ready), out_valid_r && (state_r == ST_IDLE))

endmodule

`default_nettype wire
